[design/slt_pkg.sv]
// Shared types and codes for the sorted list table.
// Depends on nothing; slt_cell and sorted_list_table import it.
`timescale 1ns / 1ps

package slt_pkg;

  localparam int VALUE_W = 32;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_FIRST  = 3'd1,
    ACT_LAST   = 3'd2,
    ACT_NEXT   = 3'd3,
    ACT_PREV   = 3'd4,
    ACT_EMPTY  = 3'd5,
    ACT_CLEAR  = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_NO_NEIGHBOR = 3'd3,
    ST_FULL        = 3'd4
  } status_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic signed [VALUE_W-1:0] entry;
    logic                      keep;
    logic                      match;
    logic                      first_hit;
    logic                      valid;
  } link_t;

  // What a cell reports to the result logic.
  typedef struct packed {
    logic pick;
    logic hit;
    logic no_nbr;
  } flag_t;

endpackage

[design/slt_cmd_if.sv]
// Command channel of the sorted list table: valid/ready plus the command fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface slt_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

[design/slt_rsp_if.sv]
// Response channel of the sorted list table: valid/ready plus the result fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface slt_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [2:0]         status;
  logic               is_empty;

  modport source (output valid, output result_value, output status, output is_empty,
                  input ready);
  modport sink (input valid, input result_value, input status, input is_empty,
                output ready);
endinterface

[design/slt_cell.sv]
// One slot of the sorted list table: holds an entry, compares it with the
// command value and shifts toward higher slots on insert. Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_cell (
  input  logic                             clk,
  input  logic                             is_head,
  input  logic                             valid,
  input  slt_pkg::action_t                 action,
  input  logic signed [slt_pkg::VALUE_W-1:0] value,
  input  logic                             shift_en,
  input  slt_pkg::link_t                   left,
  input  slt_pkg::link_t                   right,
  output slt_pkg::link_t                   link,
  output slt_pkg::flag_t                   flags
);
  import slt_pkg::*;

  logic signed [VALUE_W-1:0] entry;
  logic signed [VALUE_W-1:0] entry_next;
  logic                      keep;
  logic                      match;
  logic                      first_hit;

  always_comb begin
    keep      = valid && (entry < value);
    match     = valid && (entry == value);
    // The list is sorted, so equal copies are adjacent and the first copy
    // is the one whose left neighbor does not match.
    first_hit = match && !left.match;

    if (keep) begin
      entry_next = entry;
    end else if (is_head || left.keep) begin
      entry_next = value;
    end else begin
      entry_next = left.entry;
    end

    link = '{entry: entry, keep: keep, match: match, first_hit: first_hit, valid: valid};

    flags.hit    = first_hit;
    flags.pick   = 1'b0;
    flags.no_nbr = 1'b0;
    case (action)
      ACT_FIRST: flags.pick = is_head && valid;
      ACT_LAST:  flags.pick = valid && !right.valid;
      ACT_NEXT: begin
        flags.pick   = valid && left.first_hit;
        flags.no_nbr = first_hit && !right.valid;
      end
      ACT_PREV: begin
        flags.pick   = right.first_hit;
        flags.no_nbr = first_hit && is_head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry <= entry_next;
    end
  end

endmodule

[design/sorted_list_table.sv]
// Sorted list table: keeps up to TABLE_DEPTH signed 32-bit values in ascending order in a
// row of cells, one value per cell; every cell compares its value with the command value in
// the same cycle and shifts one slot right on insert. Each command beat yields exactly one
// response beat, registered in the cycle after acceptance. A new command is taken in every
// cycle in which the response register is empty or being drained, so the table sustains one
// command per cycle; the cell row's compare and shift decide the whole command in that cycle.
// Depends on slt_pkg, slt_cmd_if, slt_rsp_if and slt_cell.
`timescale 1ns / 1ps

module sorted_list_table #(
  parameter int TABLE_DEPTH = 16
) (
  input logic      clk,
  input logic      rst,
  slt_cmd_if.sink   cmd,
  slt_rsp_if.source rsp
);
  import slt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic                      accept;
  logic                      full;
  logic                      shift_en;
  action_t                   action;
  link_t                     lnk   [TABLE_DEPTH];
  flag_t                     flg   [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] picked;
  logic                      found;
  logic                      no_nbr;
  status_t                   status_next;
  logic signed [VALUE_W-1:0] result_next;

  logic                      rsp_valid;
  logic signed [VALUE_W-1:0] rsp_value;
  status_t                   rsp_status;
  logic                      rsp_empty;

  assign action    = action_t'(cmd.action);
  assign cmd.ready = !rsp_valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign full      = (count == CNT_W'(TABLE_DEPTH));
  assign shift_en  = accept && (action == ACT_INSERT) && !full;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    link_t left_l;
    link_t right_l;
    if (i == 0) begin : g_head
      assign left_l = '0;
    end else begin : g_mid
      assign left_l = lnk[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign right_l = '0;
    end else begin : g_body
      assign right_l = lnk[i+1];
    end

    slt_cell u_cell (
      .clk      (clk),
      .is_head  (i == 0),
      .valid    (CNT_W'(i) < count),
      .action   (action),
      .value    (cmd.value),
      .shift_en (shift_en),
      .left     (left_l),
      .right    (right_l),
      .link     (lnk[i]),
      .flags    (flg[i])
    );
  end

  always_comb begin
    picked = '0;
    found  = 1'b0;
    no_nbr = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      picked = picked | (flg[i].pick ? lnk[i].entry : '0);
      found  = found | flg[i].hit;
      no_nbr = no_nbr | flg[i].no_nbr;
    end
  end

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    case (action)
      ACT_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      ACT_FIRST, ACT_LAST: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end
      end
      ACT_NEXT, ACT_PREV: begin
        if (!found) begin
          status_next = ST_NOT_FOUND;
        end else if (no_nbr) begin
          status_next = ST_NO_NEIGHBOR;
        end
      end
      ACT_CLEAR: count_next = '0;
      default: ;
    endcase
    result_next = (status_next == ST_OK) ? picked : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_value  <= result_next;
      rsp_status <= status_next;
      rsp_empty  <= (count_next == '0);
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.result_value = rsp_value;
  assign rsp.status       = rsp_status;
  assign rsp.is_empty     = rsp_empty;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    shift_en |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the table by one");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_empty == (count == '0)))
    else $error("empty flag disagrees with entry count");

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status != ST_OK) |-> rsp_value == '0)
    else $error("nonzero result value with error status");
`endif

endmodule

[tb/sorted_list_table_tb.sv]
// Testbench for the sorted list table: directed and random commands on the command channel,
// with every response beat checked against an in-bench model of the sorted table.
// Depends on slt_pkg, slt_cmd_if, slt_rsp_if and sorted_list_table.
`timescale 1ns / 1ps

module sorted_list_table_tb;
  import slt_pkg::*;

  localparam int          DEPTH        = 16;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          HOLD_CYCLES  = 300;
  localparam logic [2:0]  ACT_UNUSED   = 3'd7;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [2:0]         action;
    logic signed [31:0] value;
  } command_t;

  typedef struct {
    logic signed [31:0] result_value;
    status_t            status;
    logic               is_empty;
  } response_t;

  logic clk;
  logic rst;

  slt_cmd_if cmd_bus ();
  slt_rsp_if rsp_bus ();

  sorted_list_table #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus.sink),
    .rsp (rsp_bus.source)
  );

  // Model of the table contents, ascending in slots 0 .. sorted_len-1.
  logic signed [31:0] sorted_vals [DEPTH];
  int                 sorted_len;

  command_t  pending_cmds [$];
  response_t awaited_rsps [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_ask;
  int  hold_seen;
  int  hold_left;
  int  fail_count;
  int  cycle_count;
  bit  cmd_taken;
  logic signed [31:0] value_pool [10];

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Applies one command to the model and returns the response it must produce.
  function automatic response_t predict_response(logic [2:0] act, logic signed [31:0] v);
    response_t r;
    int        pos;
    int        hit;
    r.result_value = '0;
    r.status       = ST_OK;
    hit = sorted_len;
    for (int i = sorted_len - 1; i >= 0; i--) begin
      if (sorted_vals[i] == v) hit = i;
    end
    case (act)
      ACT_INSERT: begin
        if (sorted_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < sorted_len && sorted_vals[pos] < v) pos++;
          for (int i = sorted_len; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
          sorted_vals[pos] = v;
          sorted_len++;
        end
      end
      ACT_FIRST, ACT_LAST: begin
        if (sorted_len == 0) r.status = ST_EMPTY;
        else if (act == ACT_FIRST) r.result_value = sorted_vals[0];
        else r.result_value = sorted_vals[sorted_len-1];
      end
      ACT_NEXT: begin
        if (hit >= sorted_len) r.status = ST_NOT_FOUND;
        else if (hit + 1 >= sorted_len) r.status = ST_NO_NEIGHBOR;
        else r.result_value = sorted_vals[hit+1];
      end
      ACT_PREV: begin
        if (hit >= sorted_len) r.status = ST_NOT_FOUND;
        else if (hit == 0) r.status = ST_NO_NEIGHBOR;
        else r.result_value = sorted_vals[hit-1];
      end
      ACT_CLEAR: sorted_len = 0;
      default: ;
    endcase
    r.is_empty = (sorted_len == 0);
    return r;
  endfunction

  // Command driver: a beat stays on the bus until it is taken.
  always @(negedge clk) begin
    command_t c;
    if (!rst && (!cmd_bus.valid || cmd_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = pending_cmds.pop_front();
        cmd_bus.action <= c.action;
        cmd_bus.value  <= c.value;
        cmd_bus.valid  <= 1'b1;
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // Response sink: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on every command beat, checks every response beat.
  always @(posedge clk) begin
    response_t want;
    if (!rst) begin
      cmd_taken <= cmd_bus.valid && cmd_bus.ready;
      if (cmd_bus.valid && cmd_bus.ready)
        awaited_rsps.push_back(predict_response(cmd_bus.action, cmd_bus.value));
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (awaited_rsps.size() == 0) begin
          $display("%0t: response beat with nothing expected (value %0d status %0d empty %0d)",
                   $time, rsp_bus.result_value, rsp_bus.status, rsp_bus.is_empty);
          fail_count++;
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp_bus.result_value !== want.result_value) begin
            $display("%0t: result_value expected %0d actual %0d",
                     $time, want.result_value, rsp_bus.result_value);
            fail_count++;
          end
          if (rsp_bus.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_bus.status);
            fail_count++;
          end
          if (rsp_bus.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %0d actual %0d",
                     $time, want.is_empty, rsp_bus.is_empty);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_cmd(logic [2:0] act, logic signed [31:0] v);
    command_t c;
    c.action = act;
    c.value  = v;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_all_done();
    while (pending_cmds.size() != 0 || cmd_bus.valid || awaited_rsps.size() != 0)
      @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(99) < 75) return value_pool[$urandom_range(9)];
    return $urandom;
  endfunction

  // Mostly inserts and lookups of values likely to be stored, with occasional clears so the
  // table keeps cycling between empty, partly filled and full.
  task automatic queue_random(int n);
    int dice;
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = 0;
    value_pool[3] = -1;
    for (int i = 4; i < 7; i++) value_pool[i] = $urandom;
    for (int i = 7; i < 10; i++) value_pool[i] = $urandom_range(40) - 20;
    for (int i = 0; i < n; i++) begin
      dice = $urandom_range(99);
      if (dice < 48) push_cmd(ACT_INSERT, pick_value());
      else if (dice < 53) push_cmd(ACT_FIRST, $urandom);
      else if (dice < 58) push_cmd(ACT_LAST, $urandom);
      else if (dice < 72) push_cmd(ACT_NEXT, pick_value());
      else if (dice < 86) push_cmd(ACT_PREV, pick_value());
      else if (dice < 93) push_cmd(ACT_EMPTY, $urandom);
      else if (dice < 97) push_cmd(ACT_CLEAR, $urandom);
      else push_cmd(ACT_UNUSED, $urandom);
    end
  endtask

  initial begin
    rst             = 1'b1;
    cmd_bus.valid   = 1'b0;
    cmd_bus.action  = ACT_INSERT;
    cmd_bus.value   = '0;
    rsp_bus.ready   = 1'b0;
    sorted_len      = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_ask        = 0;
    hold_seen       = 0;
    hold_left       = 0;
    fail_count      = 0;
    cycle_count     = 0;
    cmd_taken       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty table first, then extremes, equal copies and missing values.
    push_cmd(ACT_FIRST, 0);
    push_cmd(ACT_LAST, 0);
    push_cmd(ACT_NEXT, 0);
    push_cmd(ACT_PREV, 0);
    push_cmd(ACT_EMPTY, 0);
    push_cmd(ACT_INSERT, VAL_MAX);
    push_cmd(ACT_INSERT, VAL_MIN);
    push_cmd(ACT_INSERT, 0);
    push_cmd(ACT_INSERT, 0);
    push_cmd(ACT_INSERT, -1);
    push_cmd(ACT_FIRST, 0);
    push_cmd(ACT_LAST, 0);
    push_cmd(ACT_NEXT, VAL_MIN);
    push_cmd(ACT_NEXT, 0);
    push_cmd(ACT_PREV, 0);
    push_cmd(ACT_PREV, VAL_MIN);
    push_cmd(ACT_NEXT, VAL_MAX);
    push_cmd(ACT_NEXT, 5);
    push_cmd(ACT_PREV, 5);
    push_cmd(ACT_UNUSED, VAL_MAX);
    push_cmd(ACT_EMPTY, 0);
    push_cmd(ACT_CLEAR, 0);
    push_cmd(ACT_EMPTY, 0);
    wait_all_done();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      // In the first phase the sink holds off while beats keep coming, so the block backs up.
      if (phase == 0) hold_ask++;
      queue_random(410);
      wait_all_done();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
